// ===== sv/fbfl_pkg.sv =====
`default_nettype none

package fbfl_pkg;

    localparam int MAX_BLOCKS   = 256;
    localparam int HEADER_BYTES = 12;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int COUNT_W = 9;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int LINK_W  = IDX_W + 1;
    // dividend of the address-to-index divider; offset is below size * MAX_BLOCKS
    localparam int DIV_W   = SIZE_W + IDX_W;
    localparam int POOL_W  = SIZE_W + LINK_W;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_RANGE = 3'd2,
        STAT_ALIGN = 3'd3,
        STAT_FREED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_ADDR,
        S_CHECK,
        S_DIV,
        S_WALK,
        S_LINK_NEW,
        S_LINK_PREV,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [LINK_W-1:0] wr_link;
    } t_link_req;

endpackage

`default_nettype wire

// ===== sv/fbfl_link_ram.sv =====
`default_nettype none

module fbfl_link_ram (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fbfl_pkg::t_link_req             i_req,
    input  wire logic [fbfl_pkg::LINK_W-1:0]     i_count,
    output logic      [fbfl_pkg::LINK_W-1:0]     o_link
);

    logic [fbfl_pkg::LINK_W-1:0] r_link_mem [fbfl_pkg::MAX_BLOCKS];
    logic [fbfl_pkg::MAX_BLOCKS-1:0] r_valid;
    logic [fbfl_pkg::LINK_W-1:0] r_rd_data;
    logic [fbfl_pkg::IDX_W-1:0]  r_rd_idx;
    logic                        r_rd_valid;
    logic [fbfl_pkg::LINK_W-1:0] rd_succ;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_link_mem[i_req.wr_idx] <= i_req.wr_link;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_link_mem[i_req.rd_idx];
            r_rd_idx  <= i_req.rd_idx;
        end
    end

    // Entries not written since the last rebuild hold the address-ordered chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_idx];
            end
        end
    end

    assign rd_succ = fbfl_pkg::LINK_W'(r_rd_idx) + fbfl_pkg::LINK_W'(1);

    always_comb begin
        if (r_rd_valid) begin
            o_link = r_rd_data;
        end else if (rd_succ < i_count) begin
            o_link = rd_succ;
        end else begin
            o_link = fbfl_pkg::LINK_NULL;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fbfl_div.sv =====
`default_nettype none

module fbfl_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [fbfl_pkg::DIV_W-1:0]      i_dividend,
    input  wire logic [fbfl_pkg::SIZE_W:0]       i_divisor,
    output logic                                 o_done,
    output logic      [fbfl_pkg::IDX_W-1:0]      o_quotient,
    output logic                                 o_exact
);

    localparam int CNT_W = $clog2(fbfl_pkg::IDX_W + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [fbfl_pkg::DIV_W-1:0]   r_rem;
    logic [fbfl_pkg::DIV_W-1:0]   r_dsr;
    logic [fbfl_pkg::IDX_W-1:0]   r_quo;
    logic                         fits;

    assign fits = (r_rem >= r_dsr);

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsr <= fbfl_pkg::DIV_W'(i_divisor) << (fbfl_pkg::IDX_W - 1);
            r_cnt <= CNT_W'(fbfl_pkg::IDX_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo <= {r_quo[fbfl_pkg::IDX_W-2:0], fits};
            r_dsr <= r_dsr >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_exact    = (r_rem == '0);

endmodule

`default_nettype wire

// ===== sv/fixed_block_free_list_allocator.sv =====
// Fixed-size block pool allocator. Block i sits at base + 12 + i * S, S being the
// block size rounded up to four bytes. An allocate request (tuser 0) returns the
// lowest free block address with status 0, or status 1 when the pool is empty. A
// free request (tuser 1) returns address 0 and a status: 0 ok, 2 out of range, 3
// misaligned, 4 already free. A free that inserts a block walks past the k free
// blocks below the freed one (k at most 255); rejected frees finish sooner. A
// divider turns the offset into a block index, then the list walk reads the link
// RAM one entry per cycle. Requests are handled one at a time; a new request is
// taken while the previous result still waits at the output. Any write of registers
// 0 to 2 rebuilds the free list at once (no clearing pass); write configuration only
// while the block is idle.
`default_nettype none

module fixed_block_free_list_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [31:0]                     s_axis_tdata,   // [31:0] block_address
    input  wire logic                            s_axis_tuser,   // [0] operation
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [31:0]                     m_axis_tdata,   // [31:0] result_address
    output logic      [2:0]                      m_axis_tuser,   // [2:0] status
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);

    localparam int ADDR_W = fbfl_pkg::ADDR_W;
    localparam int SIZE_W = fbfl_pkg::SIZE_W;
    localparam int LINK_W = fbfl_pkg::LINK_W;
    localparam int IDX_W  = fbfl_pkg::IDX_W;
    localparam int PROD_W = SIZE_W + IDX_W;

    fbfl_pkg::t_state  r_state, n_state;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [SIZE_W-1:0]  r_bsize, n_bsize;
    logic [fbfl_pkg::COUNT_W-1:0] r_bcount, n_bcount;
    logic [LINK_W-1:0]  r_head, n_head;
    logic [LINK_W-1:0]  r_cur, n_cur;
    logic [LINK_W-1:0]  r_prev, n_prev;
    logic               r_from_mem, n_from_mem;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]  r_off, n_off;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    fbfl_pkg::t_status  r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    fbfl_pkg::t_status  r_out_status, n_out_status;

    logic [SIZE_W-1:0]  size_nz;
    logic [SIZE_W:0]    size_up;
    logic [SIZE_W:0]    eff_size;
    logic [LINK_W-1:0]  eff_count;
    logic [LINK_W-1:0]  cfg_count;
    logic [fbfl_pkg::POOL_W-1:0] pool_bytes;
    logic [LINK_W-1:0]  link_rd;
    logic [LINK_W-1:0]  cur_w;
    fbfl_pkg::t_link_req link_req;
    logic               div_start;
    logic               div_done;
    logic [IDX_W-1:0]   div_quo;
    logic               div_exact;
    logic               out_free;

    // largest 17-bit size rounds up to 2^17, so the stride keeps one extra bit
    assign size_nz  = (r_bsize == '0) ? SIZE_W'(1) : r_bsize;
    assign size_up  = ({1'b0, size_nz} + (SIZE_W + 1)'(3)) & ~(SIZE_W + 1)'(3);
    assign eff_size = size_up;

    assign eff_count = (r_bcount > fbfl_pkg::COUNT_W'(fbfl_pkg::MAX_BLOCKS))
                     ? fbfl_pkg::LINK_NULL : LINK_W'(r_bcount);
    assign cfg_count = (i_cfg_data[fbfl_pkg::COUNT_W-1:0]
                        > fbfl_pkg::COUNT_W'(fbfl_pkg::MAX_BLOCKS))
                     ? fbfl_pkg::LINK_NULL : LINK_W'(i_cfg_data[fbfl_pkg::COUNT_W-1:0]);

    assign pool_bytes = fbfl_pkg::POOL_W'(eff_size) * fbfl_pkg::POOL_W'(eff_count);
    assign cur_w      = r_from_mem ? link_rd : r_cur;
    assign out_free   = !r_out_valid || m_axis_tready;

    fbfl_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (link_req),
        .i_count (eff_count),
        .o_link  (link_rd)
    );

    fbfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_off[fbfl_pkg::DIV_W-1:0]),
        .i_divisor  (eff_size),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_exact    (div_exact)
    );

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_bsize      = r_bsize;
        n_bcount     = r_bcount;
        n_head       = r_head;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_from_mem   = r_from_mem;
        n_idx        = r_idx;
        n_off        = r_off;
        n_prod       = r_prod;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        link_req     = '0;
        div_start    = 1'b0;
        s_axis_tready = (r_state == fbfl_pkg::S_IDLE);

        unique case (r_state)
            fbfl_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_addr   = '0;
                    n_res_status = fbfl_pkg::STAT_OK;
                    n_off = s_axis_tdata - r_base - ADDR_W'(fbfl_pkg::HEADER_BYTES);
                    n_state = s_axis_tuser ? fbfl_pkg::S_CHECK : fbfl_pkg::S_ALLOC;
                end
            end
            fbfl_pkg::S_ALLOC: begin
                if (r_head == fbfl_pkg::LINK_NULL) begin
                    n_res_status = fbfl_pkg::STAT_EMPTY;
                    n_state      = fbfl_pkg::S_RESULT;
                end else begin
                    link_req.rd_en  = 1'b1;
                    link_req.rd_idx = r_head[IDX_W-1:0];
                    n_prod  = PROD_W'(r_head[IDX_W-1:0]) * PROD_W'(eff_size);
                    n_state = fbfl_pkg::S_ALLOC_ADDR;
                end
            end
            fbfl_pkg::S_ALLOC_ADDR: begin
                n_head     = link_rd;
                n_res_addr = r_base + ADDR_W'(fbfl_pkg::HEADER_BYTES) + ADDR_W'(r_prod);
                n_state    = fbfl_pkg::S_RESULT;
            end
            fbfl_pkg::S_CHECK: begin
                if (r_off >= ADDR_W'(pool_bytes)) begin
                    n_res_status = fbfl_pkg::STAT_RANGE;
                    n_state      = fbfl_pkg::S_RESULT;
                end else begin
                    div_start = 1'b1;
                    n_state   = fbfl_pkg::S_DIV;
                end
            end
            fbfl_pkg::S_DIV: begin
                if (div_done) begin
                    if (!div_exact) begin
                        n_res_status = fbfl_pkg::STAT_ALIGN;
                        n_state      = fbfl_pkg::S_RESULT;
                    end else begin
                        n_idx      = div_quo;
                        n_cur      = r_head;
                        n_prev     = fbfl_pkg::LINK_NULL;
                        n_from_mem = 1'b0;
                        n_state    = fbfl_pkg::S_WALK;
                    end
                end
            end
            fbfl_pkg::S_WALK: begin
                // null compares above every index, so one compare ends the walk
                if (cur_w >= {1'b0, r_idx}) begin
                    n_cur = cur_w;
                    if (cur_w == {1'b0, r_idx}) begin
                        n_res_status = fbfl_pkg::STAT_FREED;
                        n_state      = fbfl_pkg::S_RESULT;
                    end else begin
                        n_state = fbfl_pkg::S_LINK_NEW;
                    end
                end else begin
                    link_req.rd_en  = 1'b1;
                    link_req.rd_idx = cur_w[IDX_W-1:0];
                    n_prev     = cur_w;
                    n_from_mem = 1'b1;
                end
            end
            fbfl_pkg::S_LINK_NEW: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_idx  = r_idx;
                link_req.wr_link = r_cur;
                n_state = fbfl_pkg::S_LINK_PREV;
            end
            fbfl_pkg::S_LINK_PREV: begin
                if (r_prev == fbfl_pkg::LINK_NULL) begin
                    n_head = {1'b0, r_idx};
                end else begin
                    link_req.wr_en   = 1'b1;
                    link_req.wr_idx  = r_prev[IDX_W-1:0];
                    link_req.wr_link = {1'b0, r_idx};
                end
                n_state = fbfl_pkg::S_RESULT;
            end
            fbfl_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = fbfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbfl_pkg::S_IDLE;
            end
        endcase

        // a write of registers 0 to 2 rebuilds the whole chain
        if (i_cfg_we) begin
            priority if (i_cfg_index == fbfl_pkg::CFG_BASE) begin
                n_base        = i_cfg_data;
                link_req.clear = 1'b1;
                n_head = (eff_count != '0) ? '0 : fbfl_pkg::LINK_NULL;
            end else if (i_cfg_index == fbfl_pkg::CFG_SIZE) begin
                n_bsize       = i_cfg_data[SIZE_W-1:0];
                link_req.clear = 1'b1;
                n_head = (eff_count != '0) ? '0 : fbfl_pkg::LINK_NULL;
            end else if (i_cfg_index == fbfl_pkg::CFG_COUNT) begin
                n_bcount      = i_cfg_data[fbfl_pkg::COUNT_W-1:0];
                link_req.clear = 1'b1;
                n_head = (cfg_count != '0) ? '0 : fbfl_pkg::LINK_NULL;
            end else begin
                n_base = r_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbfl_pkg::S_IDLE;
            r_base      <= '0;
            r_bsize     <= SIZE_W'(4);
            r_bcount    <= fbfl_pkg::COUNT_W'(256);
            r_head      <= '0;
            r_from_mem  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_bsize     <= n_bsize;
            r_bcount    <= n_bcount;
            r_head      <= n_head;
            r_from_mem  <= n_from_mem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_idx        <= n_idx;
        r_off        <= n_off;
        r_prod       <= n_prod;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_head_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == fbfl_pkg::LINK_NULL) || (r_head < eff_count))
        else $error("free list head outside the pool");

    a_index_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_done && div_exact) |-> ({1'b0, div_quo} < eff_count))
        else $error("divider index beyond block count");

    a_walk_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbfl_pkg::S_WALK && r_from_mem) |-> (cur_w > r_prev))
        else $error("free list not in address order");

    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(link_req.rd_en && link_req.wr_en))
        else $error("link RAM read and write in one cycle");
`endif

endmodule

`default_nettype wire
